### sv/gds_pkg.sv
// shared types, constants and calendar tables for the day span block
`default_nettype none

package gds_pkg;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_ORDER   = 2'd2
	} status_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} pipe_en_t;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 22;
	localparam int QUOT_W  = 8;
	localparam int MOFF_W  = 9;

	localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_MAX   = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;

	// x / 100 == (x * RECIP_100) >> 19 for every 14 bit x
	localparam logic [26:0] RECIP_100 = 27'd5243;

	// days from march 1 to the first of the month, year taken to start in march
	function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [MOFF_W-1:0] r;
		begin
			case (m)
				4'd3:    r = 9'd0;
				4'd4:    r = 9'd31;
				4'd5:    r = 9'd61;
				4'd6:    r = 9'd92;
				4'd7:    r = 9'd122;
				4'd8:    r = 9'd153;
				4'd9:    r = 9'd184;
				4'd10:   r = 9'd214;
				4'd11:   r = 9'd245;
				4'd12:   r = 9'd275;
				4'd1:    r = 9'd306;
				4'd2:    r = 9'd337;
				default: r = 9'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		begin
			case (m) inside
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
				4'd2:                                       r = leap ? 5'd29 : 5'd28;
				default:                                    r = 5'd0;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

### sv/gds_date_num.sv
// two stage day number and validity check for one calendar date
`default_nettype none

module gds_date_num (
	input  logic                        clk,
	input  gds_pkg::pipe_en_t           en,
	input  logic [gds_pkg::DAY_W-1:0]   day,
	input  logic [gds_pkg::MONTH_W-1:0] month,
	input  logic [gds_pkg::YEAR_W-1:0]  year,
	output logic [gds_pkg::COUNT_W-1:0] num_s2,
	output logic                        ok_s2
);
	import gds_pkg::*;

	// stage 1: shifted year, quotients by 100, table lookups
	logic              early;
	logic [YEAR_W-1:0] adj_year;
	logic [26:0]       prod_y;
	logic [26:0]       prod_a;

	logic [YEAR_W-1:0]  year_s1;
	logic [YEAR_W-1:0]  adj_s1;
	logic [QUOT_W-1:0]  qy_s1;
	logic [QUOT_W-1:0]  qa_s1;
	logic [MOFF_W-1:0]  moff_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [MONTH_W-1:0] month_s1;
	logic               yok_s1;
	logic               mok_s1;

	assign early    = month < MONTH_MARCH;
	assign adj_year = early ? year - 14'd1 : year;
	assign prod_y   = {13'd0, year} * RECIP_100;
	assign prod_a   = {13'd0, adj_year} * RECIP_100;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_s1  <= year;
			adj_s1   <= adj_year;
			qy_s1    <= prod_y[26:19];
			qa_s1    <= prod_a[26:19];
			moff_s1  <= month_offset(month);
			day_s1   <= day;
			month_s1 <= month;
			yok_s1   <= (year != '0) && (year <= YEAR_MAX);
			mok_s1   <= (month != '0) && (month <= MONTH_MAX);
		end
	end

	// stage 2: leap rule, month length, day number sum
	logic [14:0]        hund;
	logic               century;
	logic               leap;
	logic [DAY_W-1:0]   mlen;
	logic [22:0]        num_c;

	assign hund    = {7'd0, qy_s1} * 15'd100;
	assign century = ({1'b0, year_s1} == hund);
	assign leap    = (year_s1[1:0] == 2'd0) && (!century || (qy_s1[1:0] == 2'd0));
	assign mlen    = month_len(month_s1, leap);

	assign num_c = {9'd0, adj_s1} * 23'd365
		+ 23'(adj_s1 >> 2)
		+ 23'(qa_s1 >> 2)
		+ 23'(moff_s1)
		+ 23'(day_s1)
		- 23'(qa_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			num_s2 <= num_c[COUNT_W-1:0];
			ok_s2  <= yok_s1 && mok_s1 && (day_s1 != '0) && (day_s1 <= mlen);
		end
	end

endmodule

`default_nettype wire

### sv/gregorian_day_span.sv
// top level: inclusive day count between two gregorian dates
`default_nettype none

// Takes one date pair per clock while the output is not stalled and returns
// the inclusive day count with a status (ok, invalid date, end before start);
// the count is 0 on any error. Three register stages: year quotients by 100
// through reciprocal multiplies, then the leap rule and the day number sum for
// each date, then the compare and difference into the output register.
// Throughput is one word per cycle without output stalls, and a stall on the
// output lets empty stages fill before the input side stops.

module gregorian_day_span (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_day, start_month, start_year, end_day, end_month, end_year, zero pad
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// day_count, zero pad
	output logic [23:0] m_axis_tdata,
	// status
	output logic [1:0]  m_axis_tuser
);
	import gds_pkg::*;

	pipe_en_t           en;
	logic               en_s3;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;

	logic [COUNT_W-1:0] num_st_s2;
	logic [COUNT_W-1:0] num_en_s2;
	logic               ok_st_s2;
	logic               ok_en_s2;

	status_t            status_c;
	logic [COUNT_W-1:0] count_c;
	status_t            status_s3;
	logic [COUNT_W-1:0] count_s3;

	assign en_s3         = !valid_s3 || m_axis_tready;
	assign en.s2         = !valid_s2 || en_s3;
	assign en.s1         = !valid_s1 || en.s2;
	assign s_axis_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_axis_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	gds_date_num u_start (
		.clk    (clk),
		.en     (en),
		.day    (s_axis_tdata[4:0]),
		.month  (s_axis_tdata[8:5]),
		.year   (s_axis_tdata[22:9]),
		.num_s2 (num_st_s2),
		.ok_s2  (ok_st_s2)
	);

	gds_date_num u_end (
		.clk    (clk),
		.en     (en),
		.day    (s_axis_tdata[27:23]),
		.month  (s_axis_tdata[31:28]),
		.year   (s_axis_tdata[45:32]),
		.num_s2 (num_en_s2),
		.ok_s2  (ok_en_s2)
	);

	always_comb begin
		status_c = ST_OK;
		count_c  = '0;
		if (!ok_st_s2 || !ok_en_s2) begin
			status_c = ST_INVALID;
		end else if (num_en_s2 < num_st_s2) begin
			status_c = ST_ORDER;
		end else begin
			count_c = num_en_s2 - num_st_s2 + 22'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			status_s3 <= status_c;
			count_s3  <= count_c;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {2'b00, count_s3};
	assign m_axis_tuser  = status_s3;

endmodule

`default_nettype wire

### sv/gds_port_check.sv
// port level checks for the day span block and their bind
`default_nettype none

module gds_port_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import gds_pkg::*;

	// an error word never carries a count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[21:0] == 22'd0)
		else $error("error word with nonzero count");

	// a good word counts at least one day and stays in range
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_OK)
		|-> (m_axis_tdata[21:0] != 22'd0) && (m_axis_tdata[21:0] <= 22'd3652059))
		else $error("good word count out of range");

	// empty output means the pipeline can take a word
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result word changed");

endmodule

bind gregorian_day_span gds_port_check u_port_check (.*);

`default_nettype wire
